// ----- rtl/bnaf_pkg.sv -----
// Shared constants and controller/datapath interface types for the attractor fitness block.
`timescale 1ns / 1ps
package bnaf_pkg;

  localparam int NUM_GENES_DEF = 5;
  localparam int IN_TABLES     = 5;
  localparam int IN_W          = 32;
  localparam int MAX_TBL_W     = 64;
  localparam int PROD_W        = 26;
  localparam int LEN_W         = 6;
  localparam int CFG_W         = 5;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TGT_ANT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_POST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ST_ANT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ST_POST  = 2'd3;

  localparam logic [CFG_W-1:0] TGT_ANT_RST  = 5'd21;
  localparam logic [CFG_W-1:0] TGT_POST_RST = 5'd10;
  localparam logic [CFG_W-1:0] ST_ANT_RST   = 5'd16;
  localparam logic [CFG_W-1:0] ST_POST_RST  = 5'd0;

  localparam logic CTX_ANT  = 1'b0;
  localparam logic CTX_POST = 1'b1;

  typedef struct packed {
    logic ctx;
    logic load_item;
    logic start_post;
    logic step_trans;
    logic step_walk;
    logic step_mul;
    logic save_ant;
    logic load_out;
  } bnaf_cmd_t;

  typedef struct packed {
    logic revisit;
    logic cyc_seen;
    logic mul_last;
  } bnaf_sts_t;

endpackage

// ----- rtl/bnaf_dp.sv -----
// Datapath: configuration, genome tables, network state, visit maps, counters and products.
`timescale 1ns / 1ps
module bnaf_dp #(
  parameter int NUM_GENES = bnaf_pkg::NUM_GENES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bnaf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bnaf_pkg::CFG_W-1:0]       cfg_data,
  input  logic [bnaf_pkg::IN_W-1:0]        in_tables [bnaf_pkg::IN_TABLES],
  input  bnaf_pkg::bnaf_cmd_t              cmd,
  output bnaf_pkg::bnaf_sts_t              sts,
  output logic [bnaf_pkg::PROD_W-1:0]      ant_prod,
  output logic [bnaf_pkg::LEN_W-1:0]       ant_len,
  output logic [bnaf_pkg::PROD_W-1:0]      post_prod,
  output logic [bnaf_pkg::LEN_W-1:0]       post_len,
  output logic                             perfect
);
  import bnaf_pkg::*;

  localparam int TBL_W  = 1 << NUM_GENES;
  localparam int CNT_W  = NUM_GENES + 1;
  localparam int GIDX_W = $clog2(NUM_GENES);

  logic [CFG_W-1:0]       tgt_ant_r, tgt_post_r, st_ant_r, st_post_r;
  logic [TBL_W-1:0]       tbl_r [NUM_GENES];
  logic [TBL_W-1:0]       tbl_load [NUM_GENES];
  logic [NUM_GENES-1:0]   state_r;
  logic [NUM_GENES-1:0]   nxt_state;
  logic [NUM_GENES-1:0]   rot_idx [NUM_GENES];
  logic [2*NUM_GENES-1:0] dbl_state;
  logic [TBL_W-1:0]       visit_r, cmap_r;
  logic [CNT_W-1:0]       cnt_r [NUM_GENES];
  logic [CNT_W-1:0]       len_r, ant_len_r;
  logic [GIDX_W-1:0]      gidx_r;
  logic [PROD_W-1:0]      prod_r, prod_nxt, ant_prod_r;
  logic [PROD_W+CNT_W-1:0] mul_full;
  logic [NUM_GENES-1:0]   tgt_sel, match;
  logic [NUM_GENES-1:0]   st_ant, st_post;

  // Genome tables: entries beyond the input width read as zero, entries beyond
  // the table size are dropped.
  for (genvar g = 0; g < NUM_GENES; g++) begin : g_tbl
    if (g < IN_TABLES) begin : g_in
      logic [MAX_TBL_W-1:0] ext;
      assign ext         = {(MAX_TBL_W-IN_W)'(0), in_tables[g]};
      assign tbl_load[g] = ext[TBL_W-1:0];
    end else begin : g_zero
      assign tbl_load[g] = '0;
    end
  end

  // One network step: bit N-1-i comes from table i at the state rotated left by i.
  always_comb begin
    dbl_state = {state_r, state_r};
    nxt_state = '0;
    for (int i = 0; i < NUM_GENES; i++) begin
      rot_idx[i] = dbl_state[(2*NUM_GENES-1-i) -: NUM_GENES];
      nxt_state[NUM_GENES-1-i] = tbl_r[i][rot_idx[i]];
    end
  end

  assign st_ant   = NUM_GENES'(st_ant_r);
  assign st_post  = NUM_GENES'(st_post_r);
  assign tgt_sel  = (cmd.ctx == CTX_POST) ? NUM_GENES'(tgt_post_r) : NUM_GENES'(tgt_ant_r);
  assign match    = ~(state_r ^ tgt_sel);
  assign mul_full = {(CNT_W)'(0), prod_r} * {(PROD_W)'(0), cnt_r[gidx_r]};
  assign prod_nxt = mul_full[PROD_W-1:0];

  assign sts.revisit  = visit_r[nxt_state];
  assign sts.cyc_seen = cmap_r[state_r];
  assign sts.mul_last = (gidx_r == GIDX_W'(NUM_GENES-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_ant_r  <= TGT_ANT_RST;
      tgt_post_r <= TGT_POST_RST;
      st_ant_r   <= ST_ANT_RST;
      st_post_r  <= ST_POST_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TGT_ANT:  tgt_ant_r  <= cfg_data;
        CFG_TGT_POST: tgt_post_r <= cfg_data;
        CFG_ST_ANT:   st_ant_r   <= cfg_data;
        CFG_ST_POST:  st_post_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      for (int i = 0; i < NUM_GENES; i++) begin
        tbl_r[i] <= tbl_load[i];
      end
      state_r <= st_ant;
      visit_r <= TBL_W'(1) << st_ant;
    end
    if (cmd.start_post) begin
      state_r <= st_post;
      visit_r <= TBL_W'(1) << st_post;
    end
    if (cmd.step_trans) begin
      state_r <= nxt_state;
      if (visit_r[nxt_state]) begin
        cmap_r <= '0;
        len_r  <= '0;
        for (int j = 0; j < NUM_GENES; j++) begin
          cnt_r[j] <= '0;
        end
      end else begin
        visit_r[nxt_state] <= 1'b1;
      end
    end
    if (cmd.step_walk) begin
      if (cmap_r[state_r]) begin
        prod_r <= PROD_W'(1);
        gidx_r <= '0;
      end else begin
        cmap_r[state_r] <= 1'b1;
        len_r           <= len_r + 1'b1;
        for (int j = 0; j < NUM_GENES; j++) begin
          cnt_r[j] <= cnt_r[j] + CNT_W'(match[j]);
        end
        state_r <= nxt_state;
      end
    end
    if (cmd.step_mul) begin
      prod_r <= prod_nxt;
      gidx_r <= gidx_r + 1'b1;
    end
    if (cmd.save_ant) begin
      ant_prod_r <= prod_nxt;
      ant_len_r  <= len_r;
    end
    if (cmd.load_out) begin
      ant_prod  <= ant_prod_r;
      ant_len   <= LEN_W'(ant_len_r);
      post_prod <= prod_r;
      post_len  <= LEN_W'(len_r);
      perfect   <= (ant_len_r == CNT_W'(1)) && (ant_prod_r == PROD_W'(1)) &&
                   (len_r == CNT_W'(1)) && (prod_r == PROD_W'(1));
    end
  end

endmodule

// ----- rtl/bnaf_ctrl.sv -----
// Controller state machine sequencing the two network runs and the result handoff.
`timescale 1ns / 1ps
module bnaf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bnaf_pkg::bnaf_sts_t sts,
  output bnaf_pkg::bnaf_cmd_t cmd
);
  import bnaf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRANS,
    S_WALK,
    S_MUL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   ctx_r, ctx_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.ctx       = ctx_r;
    state_nxt     = state_r;
    ctx_nxt       = ctx_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          ctx_nxt       = CTX_ANT;
          state_nxt     = S_TRANS;
        end
      end
      S_TRANS: begin
        cmd.step_trans = 1'b1;
        if (sts.revisit) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step_walk = 1'b1;
        if (sts.cyc_seen) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.step_mul = 1'b1;
        if (sts.mul_last) begin
          if (ctx_r == CTX_ANT) begin
            cmd.save_ant   = 1'b1;
            cmd.start_post = 1'b1;
            ctx_nxt        = CTX_POST;
            state_nxt      = S_TRANS;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctx_r       <= CTX_ANT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/boolean_network_attractor_fitness.sv -----
// Top level of the Boolean network attractor fitness block.
// Each run steps the network from its start state until a state repeats, walks the
// cycle once to count per-gene matches against the target, and multiplies the counts;
// the anterior run is followed by the posterior run and the result handoff. The
// next-state logic is stepped once a cycle.
// One genome is processed at a time; the next is accepted once the result is handed off.
// Synchronous active-low reset clears control and loads the register reset values.
`timescale 1ns / 1ps
module boolean_network_attractor_fitness #(
  parameter int NUM_GENES = bnaf_pkg::NUM_GENES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bnaf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bnaf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bnaf_pkg::IN_W-1:0]      in_gene0_table,
  input  logic [bnaf_pkg::IN_W-1:0]      in_gene1_table,
  input  logic [bnaf_pkg::IN_W-1:0]      in_gene2_table,
  input  logic [bnaf_pkg::IN_W-1:0]      in_gene3_table,
  input  logic [bnaf_pkg::IN_W-1:0]      in_gene4_table,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bnaf_pkg::PROD_W-1:0]    out_anterior_match_product,
  output logic [bnaf_pkg::LEN_W-1:0]     out_anterior_cycle_length,
  output logic [bnaf_pkg::PROD_W-1:0]    out_posterior_match_product,
  output logic [bnaf_pkg::LEN_W-1:0]     out_posterior_cycle_length,
  output logic                           out_perfect_fit
);
  import bnaf_pkg::*;

  // The genome enters as one transaction and is held in the datapath for both runs.
  logic [IN_W-1:0] in_tables [IN_TABLES];
  bnaf_cmd_t       cmd;
  bnaf_sts_t       sts;

  assign in_tables[0] = in_gene0_table;
  assign in_tables[1] = in_gene1_table;
  assign in_tables[2] = in_gene2_table;
  assign in_tables[3] = in_gene3_table;
  assign in_tables[4] = in_gene4_table;

  // The controller walks transient search, cycle walk and product for the anterior
  // context, then the posterior context, then hands the result to the output register.
  // A finished result waits there while a new transaction is already being processed.
  bnaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration registers, the tables, the visit maps and
  // the per-bit match counters, and multiplies the counts one gene per cycle.
  bnaf_dp #(
    .NUM_GENES (NUM_GENES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_tables (in_tables),
    .cmd       (cmd),
    .sts       (sts),
    .ant_prod  (out_anterior_match_product),
    .ant_len   (out_anterior_cycle_length),
    .post_prod (out_posterior_match_product),
    .post_len  (out_posterior_cycle_length),
    .perfect   (out_perfect_fit)
  );

endmodule
